[rtl/gcs_pkg.sv]
// Shared constants, register and slot codes, and types for the grid corner synthesis block.
package gcs_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 20;

    // Field widths of the corner indexes and the size registers.
    localparam int COL_W  = 11;
    localparam int ROW_W  = 13;
    localparam int IDX_W  = $clog2(MAX_COLUMNS);
    localparam int RIDX_W = $clog2(MAX_ROWS);

    // Room for four coordinates plus two 360 degree shifts.
    localparam int OFF_W = FRAC_BITS + 10;
    localparam int SUM_W = ((COORD_WIDTH > OFF_W) ? COORD_WIDTH : OFF_W) + 3;

    localparam logic signed [SUM_W-1:0] DEG360 = SUM_W'(64'd360 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] DEG720 = SUM_W'(64'd720 << FRAC_BITS);

    localparam int DATA_W = 2 * COORD_WIDTH;

    // Configuration port.
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int PDATA_W   = 32;
    localparam logic [REG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WRAP      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BAND_LO   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BAND_HI   = 3'd4;

    // Corner slots of one cell, in emission order.
    localparam int NSLOT  = 6;
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_INNER     = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_WEST      = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_EAST      = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_TOP_INNER = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_TOP_WEST  = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_TOP_EAST  = 3'd5;

    typedef struct packed {
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
        logic             wrap_en;
        logic [ROW_W-1:0] band_lo;
        logic [ROW_W-1:0] band_hi;
    } gcs_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]              ci;
        logic [RIDX_W-1:0]             cj;
        logic                          below;
        logic                          first;
        logic [NSLOT-1:0]              mask;
        logic signed [COORD_WIDTH-1:0] c_lon;
        logic signed [COORD_WIDTH-1:0] c_lat;
        logic signed [COORD_WIDTH-1:0] left_lon;
        logic signed [COORD_WIDTH-1:0] left_lat;
        logic signed [COORD_WIDTH-1:0] rf_lon;
        logic signed [COORD_WIDTH-1:0] rf_lat;
    } gcs_item_t;

    typedef struct packed {
        logic [COL_W-1:0]             col;
        logic [ROW_W-1:0]             row;
        logic [3:0][COORD_WIDTH-1:0]  lon;
        logic [3:0][COORD_WIDTH-1:0]  lat;
        logic [3:0]                   ok;
        logic signed [SUM_W-1:0]      off;
        logic                         last;
        logic                         done;
    } gcs_corner_t;

endpackage

[rtl/gcs_ram.sv]
// Generic simple dual-port RAM with registered read data.
module gcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old entry when read and write hit the same address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gcs_front.sv]
// Input side: raster counters, line buffer read-modify-write and the request register.
module gcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcs_pkg::gcs_cfg_t             cfg,
    input  logic                          restart,
    input  logic                          center_valid,
    output logic                          center_stall,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] cell_lon,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] cell_lat,
    input  logic                          take,
    output logic                          item_valid,
    output gcs_pkg::gcs_item_t            item,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lon,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lat
);

    logic [gcs_pkg::IDX_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [gcs_pkg::RIDX_W-1:0] row_cnt_reg, row_cnt_next;
    logic                       item_valid_reg, item_valid_next;
    gcs_pkg::gcs_item_t         item_reg, item_next;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] left_lon_reg, left_lat_reg;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] rf_lon_reg, rf_lat_reg;

    logic                       accept;
    logic [gcs_pkg::IDX_W-1:0]  ci;
    logic [gcs_pkg::RIDX_W-1:0] cj;
    logic                       row_end, top_row, inner, band_j, band_top;
    logic [gcs_pkg::DATA_W-1:0] rdata;

    assign center_stall = item_valid_reg && !take;
    assign accept       = center_valid && !center_stall;

    always_comb
    begin
        ci = (gcs_pkg::COL_W'(col_cnt_reg) >= cfg.cols) ? '0 : col_cnt_reg;
        cj = (gcs_pkg::ROW_W'(row_cnt_reg) >= cfg.rows) ? '0 : row_cnt_reg;
        row_end  = (gcs_pkg::COL_W'(ci) == cfg.cols - gcs_pkg::COL_W'(1));
        top_row  = (gcs_pkg::ROW_W'(cj) == cfg.rows - gcs_pkg::ROW_W'(1));
        inner    = (ci != '0);
        band_j   = (gcs_pkg::ROW_W'(cj) >= cfg.band_lo) && (gcs_pkg::ROW_W'(cj) <= cfg.band_hi);
        band_top = (cfg.rows >= cfg.band_lo) && (cfg.rows <= cfg.band_hi);

        item_next          = item_reg;
        item_next.ci       = ci;
        item_next.cj       = cj;
        item_next.below    = (cj != '0);
        item_next.first    = !inner;
        item_next.c_lon    = cell_lon;
        item_next.c_lat    = cell_lat;
        item_next.left_lon = left_lon_reg;
        item_next.left_lat = left_lat_reg;
        item_next.rf_lon   = inner ? rf_lon_reg : cell_lon;
        item_next.rf_lat   = inner ? rf_lat_reg : cell_lat;
        item_next.mask     = '0;
        item_next.mask[gcs_pkg::SLOT_INNER]     = inner && band_j;
        item_next.mask[gcs_pkg::SLOT_WEST]      = row_end && band_j;
        item_next.mask[gcs_pkg::SLOT_EAST]      = row_end && band_j;
        item_next.mask[gcs_pkg::SLOT_TOP_INNER] = top_row && inner && band_top;
        item_next.mask[gcs_pkg::SLOT_TOP_WEST]  = top_row && row_end && band_top;
        item_next.mask[gcs_pkg::SLOT_TOP_EAST]  = top_row && row_end && band_top;

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (restart)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = top_row ? '0 : cj + gcs_pkg::RIDX_W'(1);
            end
            else
            begin
                col_cnt_next = ci + gcs_pkg::IDX_W'(1);
                row_cnt_next = cj;
            end
        end

        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            item_valid_reg <= 1'b0;
            left_lon_reg   <= '0;
            left_lat_reg   <= '0;
            rf_lon_reg     <= '0;
            rf_lat_reg     <= '0;
        end
        else
        begin
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            item_valid_reg <= item_valid_next;
            if (accept)
            begin
                left_lon_reg <= cell_lon;
                left_lat_reg <= cell_lat;
                rf_lon_reg   <= item_next.rf_lon;
                rf_lat_reg   <= item_next.rf_lat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    // Line buffer: read the cell below and overwrite it with this one in the same cycle.
    gcs_ram #(
        .WIDTH (gcs_pkg::DATA_W),
        .DEPTH (gcs_pkg::MAX_COLUMNS)
    ) u_line_buf (
        .clk   (clk),
        .re    (accept),
        .raddr (ci),
        .we    (accept),
        .waddr (ci),
        .wdata ({cell_lat, cell_lon}),
        .rdata (rdata)
    );

    assign b_lon      = rdata[gcs_pkg::COORD_WIDTH-1:0];
    assign b_lat      = rdata[gcs_pkg::DATA_W-1:gcs_pkg::COORD_WIDTH];
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

[rtl/gcs_emit.sv]
// Corner sequencer: walks the pending corner slots of one cell and picks their four cells.
module gcs_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcs_pkg::gcs_cfg_t             cfg,
    input  logic                          item_valid,
    input  gcs_pkg::gcs_item_t            item,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lon,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lat,
    output logic                          take,
    output logic                          corner_valid,
    output gcs_pkg::gcs_corner_t          corner,
    input  logic                          corner_ready
);

    gcs_pkg::gcs_item_t       ctx_reg;
    logic [gcs_pkg::NSLOT-1:0] mask_reg, mask_next;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lon_reg, b_lat_reg;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] d_lon_reg, d_lat_reg;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] bf_lon_reg, bf_lat_reg;
    // Running state: below cell of the previous cell, below cell of column 0.
    logic signed [gcs_pkg::COORD_WIDTH-1:0] diag_lon_reg, diag_lat_reg;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] bfs_lon_reg, bfs_lat_reg;

    logic [gcs_pkg::NSLOT-1:0] cur_bit, rest;
    logic [gcs_pkg::SLOT_W-1:0] slot;
    logic                      fire, free;
    logic                      w, bw;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] bf_lon_new, bf_lat_new;

    function automatic logic signed [gcs_pkg::SUM_W-1:0] lon_shift(
        input logic neg,
        input logic a,
        input logic b
    );
        logic signed [gcs_pkg::SUM_W-1:0] mag;
        mag = (a && b) ? gcs_pkg::DEG720 : ((a || b) ? gcs_pkg::DEG360 : '0);
        return neg ? -mag : mag;
    endfunction

    assign cur_bit      = mask_reg & (~mask_reg + gcs_pkg::NSLOT'(1));
    assign rest         = mask_reg & ~cur_bit;
    assign corner_valid = (mask_reg != '0);
    assign fire         = corner_valid && corner_ready;
    assign free         = !corner_valid || (fire && (rest == '0));
    assign take         = item_valid && free;
    assign w            = cfg.wrap_en;
    assign bw           = ctx_reg.below && cfg.wrap_en;
    assign bf_lon_new   = item.first ? b_lon : bfs_lon_reg;
    assign bf_lat_new   = item.first ? b_lat : bfs_lat_reg;

    always_comb
    begin
        slot = '0;
        for (int k = gcs_pkg::NSLOT - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                slot = gcs_pkg::SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        corner      = '0;
        corner.last = (rest == '0);
        corner.col  = gcs_pkg::COL_W'(ctx_reg.ci);
        corner.row  = gcs_pkg::ROW_W'(ctx_reg.cj);
        case (slot)
            gcs_pkg::SLOT_INNER:
            begin
                corner.lon = {ctx_reg.c_lon, ctx_reg.left_lon, b_lon_reg, d_lon_reg};
                corner.lat = {ctx_reg.c_lat, ctx_reg.left_lat, b_lat_reg, d_lat_reg};
                corner.ok  = {1'b1, 1'b1, ctx_reg.below, ctx_reg.below};
            end
            gcs_pkg::SLOT_WEST:
            begin
                corner.col = '0;
                corner.lon = {ctx_reg.rf_lon, ctx_reg.c_lon, bf_lon_reg, b_lon_reg};
                corner.lat = {ctx_reg.rf_lat, ctx_reg.c_lat, bf_lat_reg, b_lat_reg};
                corner.ok  = {1'b1, w, ctx_reg.below, bw};
                corner.off = lon_shift(1'b1, bw, w);
            end
            gcs_pkg::SLOT_EAST:
            begin
                corner.col = cfg.cols;
                corner.lon = {ctx_reg.rf_lon, ctx_reg.c_lon, bf_lon_reg, b_lon_reg};
                corner.lat = {ctx_reg.rf_lat, ctx_reg.c_lat, bf_lat_reg, b_lat_reg};
                corner.ok  = {w, 1'b1, bw, ctx_reg.below};
                corner.off = lon_shift(1'b0, bw, w);
            end
            gcs_pkg::SLOT_TOP_INNER:
            begin
                corner.row       = cfg.rows;
                corner.lon[1:0]  = {ctx_reg.c_lon, ctx_reg.left_lon};
                corner.lat[1:0]  = {ctx_reg.c_lat, ctx_reg.left_lat};
                corner.ok        = 4'b0011;
            end
            gcs_pkg::SLOT_TOP_WEST:
            begin
                corner.col       = '0;
                corner.row       = cfg.rows;
                corner.lon[1:0]  = {ctx_reg.rf_lon, ctx_reg.c_lon};
                corner.lat[1:0]  = {ctx_reg.rf_lat, ctx_reg.c_lat};
                corner.ok        = {2'b00, 1'b1, w};
                corner.off       = lon_shift(1'b1, w, 1'b0);
            end
            gcs_pkg::SLOT_TOP_EAST:
            begin
                corner.col       = cfg.cols;
                corner.row       = cfg.rows;
                corner.lon[1:0]  = {ctx_reg.rf_lon, ctx_reg.c_lon};
                corner.lat[1:0]  = {ctx_reg.rf_lat, ctx_reg.c_lat};
                corner.ok        = {2'b00, w, 1'b1};
                corner.off       = lon_shift(1'b0, w, 1'b0);
                corner.done      = 1'b1;
            end
            default:
            begin
                corner.ok = '0;
            end
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            mask_next = item.mask;
        end
        else if (fire)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            diag_lon_reg <= '0;
            diag_lat_reg <= '0;
            bfs_lon_reg  <= '0;
            bfs_lat_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (take)
            begin
                diag_lon_reg <= b_lon;
                diag_lat_reg <= b_lat;
                bfs_lon_reg  <= bf_lon_new;
                bfs_lat_reg  <= bf_lat_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctx_reg    <= item;
            b_lon_reg  <= b_lon;
            b_lat_reg  <= b_lat;
            d_lon_reg  <= diag_lon_reg;
            d_lat_reg  <= diag_lat_reg;
            bf_lon_reg <= bf_lon_new;
            bf_lat_reg <= bf_lat_new;
        end
    end

endmodule

[rtl/gcs_avg.sv]
// Corner averaging: sum stage, then floor shift, saturation and the output register.
module gcs_avg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          corner_valid,
    input  gcs_pkg::gcs_corner_t          corner,
    output logic                          corner_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gcs_pkg::COL_W-1:0]     out_col,
    output logic [gcs_pkg::ROW_W-1:0]     out_row,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] out_lon,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] out_lat,
    output logic                          out_last,
    output logic                          out_done
);

    logic                         a_valid_reg, a_valid_next;
    logic signed [gcs_pkg::SUM_W-1:0] sum_lon_reg, sum_lat_reg;
    logic [1:0]                   sh_reg;
    logic [gcs_pkg::COL_W-1:0]    a_col_reg;
    logic [gcs_pkg::ROW_W-1:0]    a_row_reg;
    logic                         a_last_reg, a_done_reg;

    logic                         o_valid_reg, o_valid_next;
    logic [gcs_pkg::COL_W-1:0]    o_col_reg;
    logic [gcs_pkg::ROW_W-1:0]    o_row_reg;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] o_lon_reg, o_lat_reg;
    logic                         o_last_reg, o_done_reg;

    logic                         o_ready, a_load;
    logic signed [gcs_pkg::SUM_W-1:0] sum_lon, sum_lat;
    logic [2:0]                   cnt;
    logic [1:0]                   sh;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] avg_lon, avg_lat;

    function automatic logic signed [gcs_pkg::COORD_WIDTH-1:0] shift_sat(
        input logic signed [gcs_pkg::SUM_W-1:0] s,
        input logic [1:0]                       k
    );
        logic signed [gcs_pkg::SUM_W-1:0] q;
        logic [gcs_pkg::SUM_W-gcs_pkg::COORD_WIDTH:0] top;
        q   = s >>> k;
        top = q[gcs_pkg::SUM_W-1:gcs_pkg::COORD_WIDTH-1];
        if ((top == '0) || (top == '1))
        begin
            return q[gcs_pkg::COORD_WIDTH-1:0];
        end
        else if (q[gcs_pkg::SUM_W-1])
        begin
            return {1'b1, {(gcs_pkg::COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(gcs_pkg::COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    assign o_ready      = !o_valid_reg || !out_stall;
    assign corner_ready = !a_valid_reg || o_ready;
    assign a_load       = corner_valid && corner_ready;

    always_comb
    begin
        sum_lon = corner.off;
        sum_lat = '0;
        cnt     = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (corner.ok[k])
            begin
                sum_lon = sum_lon + gcs_pkg::SUM_W'($signed(corner.lon[k]));
                sum_lat = sum_lat + gcs_pkg::SUM_W'($signed(corner.lat[k]));
                cnt     = cnt + 3'd1;
            end
        end
        // Cell counts of four, two or one.
        sh = (cnt >= 3'd4) ? 2'd2 : ((cnt >= 3'd2) ? 2'd1 : 2'd0);

        a_valid_next = corner_ready ? corner_valid : 1'b1;
        o_valid_next = o_ready ? a_valid_reg : 1'b1;
        avg_lon      = shift_sat(sum_lon_reg, sh_reg);
        avg_lat      = shift_sat(sum_lat_reg, sh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            sum_lon_reg <= sum_lon;
            sum_lat_reg <= sum_lat;
            sh_reg      <= sh;
            a_col_reg   <= corner.col;
            a_row_reg   <= corner.row;
            a_last_reg  <= corner.last;
            a_done_reg  <= corner.done;
        end
        if (o_ready && a_valid_reg)
        begin
            o_col_reg  <= a_col_reg;
            o_row_reg  <= a_row_reg;
            o_lon_reg  <= avg_lon;
            o_lat_reg  <= avg_lat;
            o_last_reg <= a_last_reg;
            o_done_reg <= a_done_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_col   = o_col_reg;
    assign out_row   = o_row_reg;
    assign out_lon   = o_lon_reg;
    assign out_lat   = o_lat_reg;
    assign out_last  = o_last_reg;
    assign out_done  = o_done_reg;

endmodule

[rtl/grid_corner_synthesis_core.sv]
// Top level: configuration registers and the line buffer corner pipeline.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------------------
//  center   | center_valid / center_stall | cell_lon, cell_lat
//  corner   | corner_valid / corner_stall | corner_col, corner_row, node_lon,
//           |                             | node_lat, last_of_item, grid_done
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// The corner sequencer emits one corner per cycle while the output is not stalled,
// up to six for a row-end cell in the last row, and takes the next cell as the last
// corner goes out. A cell passes the request register and line buffer read, the
// sequencer, the sum register, then shift and saturate into the output register.
// The line buffer needs no clearing after reset; its read data is used only for rows already written.
// A stall on the corner side fills the pipeline, then stalls the center side.
module grid_corner_synthesis_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gcs_pkg::ADDR_W-1:0]             paddr,
    input  logic [gcs_pkg::PDATA_W-1:0]            pwdata,
    output logic [gcs_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   center_valid,
    output logic                                   center_stall,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] cell_lon,
    input  logic signed [gcs_pkg::COORD_WIDTH-1:0] cell_lat,
    output logic                                   corner_valid,
    input  logic                                   corner_stall,
    output logic [gcs_pkg::COL_W-1:0]              corner_col,
    output logic [gcs_pkg::ROW_W-1:0]              corner_row,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] node_lon,
    output logic signed [gcs_pkg::COORD_WIDTH-1:0] node_lat,
    output logic                                   last_of_item,
    output logic                                   grid_done
);

    logic [gcs_pkg::COL_W-1:0] columns_reg;
    logic [gcs_pkg::ROW_W-1:0] rows_reg;
    logic                      wrap_reg;
    logic [gcs_pkg::ROW_W-1:0] band_lo_reg;
    logic [gcs_pkg::ROW_W-1:0] band_hi_reg;

    logic                          wr_en, restart;
    logic [gcs_pkg::REG_IDX_W-1:0] reg_idx;
    gcs_pkg::gcs_cfg_t             cfg;

    logic                          item_valid, take;
    gcs_pkg::gcs_item_t            item;
    logic signed [gcs_pkg::COORD_WIDTH-1:0] b_lon, b_lat;
    logic                          em_valid, em_ready;
    gcs_pkg::gcs_corner_t          em_corner;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[gcs_pkg::ADDR_W-1:2];
    assign restart = wr_en && ((reg_idx == gcs_pkg::REG_COLUMNS) ||
                               (reg_idx == gcs_pkg::REG_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= gcs_pkg::COL_W'(1);
            rows_reg    <= gcs_pkg::ROW_W'(1);
            wrap_reg    <= 1'b0;
            band_lo_reg <= '0;
            band_hi_reg <= gcs_pkg::ROW_W'(gcs_pkg::MAX_ROWS);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gcs_pkg::REG_COLUMNS: columns_reg <= pwdata[gcs_pkg::COL_W-1:0];
                gcs_pkg::REG_ROWS:    rows_reg    <= pwdata[gcs_pkg::ROW_W-1:0];
                gcs_pkg::REG_WRAP:    wrap_reg    <= pwdata[0];
                gcs_pkg::REG_BAND_LO: band_lo_reg <= pwdata[gcs_pkg::ROW_W-1:0];
                gcs_pkg::REG_BAND_HI: band_hi_reg <= pwdata[gcs_pkg::ROW_W-1:0];
                default:              wrap_reg    <= wrap_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gcs_pkg::REG_COLUMNS: prdata = gcs_pkg::PDATA_W'(columns_reg);
            gcs_pkg::REG_ROWS:    prdata = gcs_pkg::PDATA_W'(rows_reg);
            gcs_pkg::REG_WRAP:    prdata = gcs_pkg::PDATA_W'(wrap_reg);
            gcs_pkg::REG_BAND_LO: prdata = gcs_pkg::PDATA_W'(band_lo_reg);
            gcs_pkg::REG_BAND_HI: prdata = gcs_pkg::PDATA_W'(band_hi_reg);
            default:              prdata = '0;
        endcase
    end

    // Clamp sizes into range, clip the top of the band to the grid, and enable wrap only for two or more columns.
    always_comb
    begin
        if (columns_reg == '0)
        begin
            cfg.cols = gcs_pkg::COL_W'(1);
        end
        else if (columns_reg > gcs_pkg::COL_W'(gcs_pkg::MAX_COLUMNS))
        begin
            cfg.cols = gcs_pkg::COL_W'(gcs_pkg::MAX_COLUMNS);
        end
        else
        begin
            cfg.cols = columns_reg;
        end

        if (rows_reg == '0)
        begin
            cfg.rows = gcs_pkg::ROW_W'(1);
        end
        else if (rows_reg > gcs_pkg::ROW_W'(gcs_pkg::MAX_ROWS))
        begin
            cfg.rows = gcs_pkg::ROW_W'(gcs_pkg::MAX_ROWS);
        end
        else
        begin
            cfg.rows = rows_reg;
        end

        cfg.wrap_en = wrap_reg && (cfg.cols >= gcs_pkg::COL_W'(2));
        cfg.band_lo = band_lo_reg;
        cfg.band_hi = (band_hi_reg > cfg.rows) ? cfg.rows : band_hi_reg;
    end

    gcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .restart      (restart),
        .center_valid (center_valid),
        .center_stall (center_stall),
        .cell_lon     (cell_lon),
        .cell_lat     (cell_lat),
        .take         (take),
        .item_valid   (item_valid),
        .item         (item),
        .b_lon        (b_lon),
        .b_lat        (b_lat)
    );

    gcs_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .b_lon        (b_lon),
        .b_lat        (b_lat),
        .take         (take),
        .corner_valid (em_valid),
        .corner       (em_corner),
        .corner_ready (em_ready)
    );

    gcs_avg u_avg (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (em_valid),
        .corner       (em_corner),
        .corner_ready (em_ready),
        .out_valid    (corner_valid),
        .out_stall    (corner_stall),
        .out_col      (corner_col),
        .out_row      (corner_row),
        .out_lon      (node_lon),
        .out_lat      (node_lat),
        .out_last     (last_of_item),
        .out_done     (grid_done)
    );

endmodule
